// ===== rtl/core/tmcw_pkg.sv =====
// Shared types and constants for the text-mode console writer.
// Holds port widths, character codes, action and state encodings, and the
// command and status structs that join the controller to the datapath.
package tmcw_pkg;

  // Default screen geometry.
  localparam int ROWS_DEF    = 25;
  localparam int COLUMNS_DEF = 80;

  // Fixed port widths.
  localparam int ACT_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int ROW_OUT_W  = 5;
  localparam int COL_OUT_W  = 7;
  localparam int LIN_OUT_W  = 11;
  localparam int CELL_BITS  = 16;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register word index within the configuration space.
  localparam logic REG_TEXT_COLOUR = 1'b0;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  // Light grey on black.
  localparam logic [ATTR_W-1:0] RESET_COLOUR = 8'h07;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_BOOT,
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic boot_fill;
    logic fill_step;
    logic load_out;
  } tmcw_cmd_t;

  typedef struct packed {
    logic need_fill;
    logic fill_done;
  } tmcw_sts_t;

endpackage

// ===== rtl/core/tmcw_ctrl.sv =====
// Controller state machine for the text-mode console writer.
// Depends on tmcw_pkg; drives the datapath through tmcw_cmd_t commands.
module tmcw_ctrl
  import tmcw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  tmcw_sts_t sts,
  output tmcw_cmd_t cmd
);

  state_t state, state_next;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_BOOT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_BOOT: begin
        state_next = ST_INIT;
      end
      ST_INIT: begin
        if (sts.fill_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = sts.need_fill ? ST_FILL : ST_DONE;
      end
      ST_FILL: begin
        if (sts.fill_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = in_valid ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_next = ST_BOOT;
      end
    endcase
  end

  always_comb begin
    in_stall      = !((state == ST_IDLE) || ((state == ST_DONE) && out_free));
    accept        = in_valid && !in_stall;
    cmd.load_item = accept;
    cmd.exec      = (state == ST_EXEC);
    cmd.boot_fill = (state == ST_BOOT);
    cmd.fill_step = (state == ST_INIT) || (state == ST_FILL);
    cmd.load_out  = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // An accepted item always goes straight into execution.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC))
    else $error("accepted item did not enter execution");

  // A finished fill sweep hands over to result delivery.
  a_fill_exit: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FILL) && sts.fill_done) |=> (state == ST_DONE))
    else $error("fill sweep did not end");

  // Loading the output register always presents a result.
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result loaded but not presented");

endmodule

// ===== rtl/core/tmcw_datapath.sv =====
// Datapath of the text-mode console writer: cell memory, cursor, scroll
// offset, fill sweep and output registers. Depends on tmcw_pkg.
module tmcw_datapath
  import tmcw_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tmcw_cmd_t             cmd,
  output tmcw_sts_t             sts,
  input  logic [ATTR_W-1:0]     text_colour,
  input  logic [ACT_W-1:0]      action,
  input  logic [CHAR_W-1:0]     char_code,
  input  logic [ROW_OUT_W-1:0]  read_row,
  input  logic [COL_OUT_W-1:0]  read_col,
  output logic [ROW_OUT_W-1:0]  cursor_row_out,
  output logic [COL_OUT_W-1:0]  cursor_col_out,
  output logic [LIN_OUT_W-1:0]  cursor_linear,
  output logic [CELL_BITS-1:0]  cell_value
);

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int CELLS  = ROWS * COLUMNS;
  localparam int CELL_W = $clog2(CELLS);

  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);
  localparam logic [COL_W:0]    TAB_STEP  = (COL_W + 1)'(4);
  localparam logic [COL_W:0]    TAB_MASK  = ~((COL_W + 1)'(3));

  // Screen rows are kept in a ring: logical row r lives at physical row
  // (r + top_row) mod ROWS, so a scroll only moves top_row.
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] t);
    logic [ROW_W:0] s;
    s = {1'b0, r} + {1'b0, t};
    if (s >= (ROW_W + 1)'(ROWS)) s = s - (ROW_W + 1)'(ROWS);
    return s[ROW_W-1:0];
  endfunction

  function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    logic [CELL_W-1:0] base;
    base = CELL_W'(r) * CELL_W'(COLUMNS);
    return base + CELL_W'(c);
  endfunction

  // Latched item.
  logic [ACT_W-1:0]     act;
  logic [CHAR_W-1:0]    ch;
  logic [ROW_OUT_W-1:0] rd_row;
  logic [COL_OUT_W-1:0] rd_col;

  // Cursor and ring offset.
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] top_row;

  // Fill sweep.
  logic [CELL_W-1:0] fill_addr;
  logic [CELL_W-1:0] fill_last;
  logic [ATTR_W-1:0] fill_attr;
  logic [CELL_W-1:0] top_base;

  // Cell memory.
  logic [CELL_BITS-1:0] screen [CELLS];
  logic [CELL_BITS-1:0] rd_data;
  logic                 rd_ok;
  logic                 mem_we;
  logic [CELL_W-1:0]    mem_waddr;
  logic [CELL_BITS-1:0] mem_wdata;
  logic [CELL_W-1:0]    rd_addr;
  logic                 rd_in_range;

  // Put decode.
  logic [ROW_W-1:0]  row_nx;
  logic [COL_W-1:0]  col_nx;
  logic [ROW_W-1:0]  wr_row;
  logic [COL_W-1:0]  wr_col;
  logic [CHAR_W-1:0] wr_char;
  logic [COL_W:0]    tab_col;
  logic              wr_en;
  logic              adv_row;
  logic              scroll;
  logic              is_put;
  logic [CELL_W-1:0] lin_full;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act    <= action;
      ch     <= char_code;
      rd_row <= read_row;
      rd_col <= read_col;
    end
  end

  assign is_put = (act == ACT_PUT);

  always_comb begin
    tab_col = ({1'b0, cur_col} + TAB_STEP) & TAB_MASK;
    row_nx  = cur_row;
    col_nx  = cur_col;
    wr_row  = cur_row;
    wr_col  = cur_col;
    wr_char = ch;
    wr_en   = 1'b0;
    adv_row = 1'b0;
    case (ch)
      CH_NEWLINE: begin
        col_nx  = '0;
        adv_row = 1'b1;
      end
      CH_RETURN: begin
        col_nx = '0;
      end
      CH_TAB: begin
        if (tab_col >= (COL_W + 1)'(COLUMNS)) begin
          col_nx  = '0;
          adv_row = 1'b1;
        end else begin
          col_nx = tab_col[COL_W-1:0];
        end
      end
      CH_BACKSPACE: begin
        if (cur_col != '0) begin
          col_nx = cur_col - COL_W'(1);
        end else if (cur_row != '0) begin
          row_nx = cur_row - ROW_W'(1);
          col_nx = LAST_COL;
        end
        wr_row  = row_nx;
        wr_col  = col_nx;
        wr_char = CH_SPACE;
        wr_en   = 1'b1;
      end
      default: begin
        wr_en = 1'b1;
        if (cur_col == LAST_COL) begin
          col_nx  = '0;
          adv_row = 1'b1;
        end else begin
          col_nx = cur_col + COL_W'(1);
        end
      end
    endcase
    scroll = adv_row && (cur_row == LAST_ROW);
    if (adv_row && !scroll) row_nx = cur_row + ROW_W'(1);
  end

  always_comb begin
    sts.need_fill = (act == ACT_CLEAR) || (is_put && scroll);
    sts.fill_done = (fill_addr == fill_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
      top_row <= '0;
    end else if (cmd.exec) begin
      case (act)
        ACT_PUT: begin
          cur_row <= row_nx;
          cur_col <= col_nx;
          if (scroll) top_row <= (top_row == LAST_ROW) ? '0 : top_row + ROW_W'(1);
        end
        ACT_CLEAR: begin
          cur_row <= '0;
          cur_col <= '0;
          top_row <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // On a scroll the old top physical row becomes the new bottom row.
  assign top_base = cell_addr(top_row, '0);

  always_ff @(posedge clk) begin
    if (cmd.boot_fill) begin
      fill_addr <= '0;
      fill_last <= LAST_CELL;
      fill_attr <= RESET_COLOUR;
    end else if (cmd.exec && (act == ACT_CLEAR)) begin
      fill_addr <= '0;
      fill_last <= LAST_CELL;
      fill_attr <= text_colour;
    end else if (cmd.exec && is_put && scroll) begin
      fill_addr <= top_base;
      fill_last <= top_base + CELL_W'(LAST_COL);
      fill_attr <= text_colour;
    end else if (cmd.fill_step) begin
      fill_addr <= fill_addr + CELL_W'(1);
    end
  end

  always_comb begin
    if (cmd.fill_step) begin
      mem_we    = 1'b1;
      mem_waddr = fill_addr;
      mem_wdata = {fill_attr, CH_SPACE};
    end else begin
      mem_we    = cmd.exec && is_put && wr_en;
      mem_waddr = cell_addr(phys_row(wr_row, top_row), wr_col);
      mem_wdata = {text_colour, wr_char};
    end
  end

  assign rd_in_range = (int'(rd_row) < ROWS) && (int'(rd_col) < COLUMNS);
  assign rd_addr     = cell_addr(phys_row(ROW_W'(rd_row), top_row), COL_W'(rd_col));

  always_ff @(posedge clk) begin
    if (mem_we) screen[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && (act == ACT_READ) && rd_in_range) rd_data <= screen[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) rd_ok <= (act == ACT_READ) && rd_in_range;
  end

  assign lin_full = cell_addr(cur_row, cur_col);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cursor_row_out <= ROW_OUT_W'(cur_row);
      cursor_col_out <= COL_OUT_W'(cur_col);
      cursor_linear  <= LIN_OUT_W'(lin_full);
      cell_value     <= rd_ok ? rd_data : '0;
    end
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    cur_col <= LAST_COL)
    else $error("cursor column past the right edge");

  a_top_range: assert property (@(posedge clk) disable iff (rst)
    top_row <= LAST_ROW)
    else $error("ring offset out of range");

  // A scroll leaves the cursor on the bottom row.
  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && is_put && scroll) |=> (cur_row == LAST_ROW))
    else $error("scroll did not keep the cursor on the bottom row");

endmodule

// ===== rtl/core/text_mode_console_writer.sv =====
// Text-mode console writer: a put, a plain read or an unused action runs in the execute
// state and has its result loaded in the done state; a new item can be taken as a result
// is loaded if the output register is free. A put that scrolls adds a sweep writing one
// blank cell per cycle in the new bottom row, and a clear one over all ROWS*COLUMNS cells,
// both through the single memory write port. After the synchronous reset a clearing pass
// blanks the store in colour 7; no item is taken during it, but configuration writes are.
module text_mode_console_writer
  import tmcw_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Input channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ACT_W-1:0]      action,
  input  logic [CHAR_W-1:0]     char_code,
  input  logic [ROW_OUT_W-1:0]  read_row,
  input  logic [COL_OUT_W-1:0]  read_col,
  // Output channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ROW_OUT_W-1:0]  cursor_row_out,
  output logic [COL_OUT_W-1:0]  cursor_col_out,
  output logic [LIN_OUT_W-1:0]  cursor_linear,
  output logic [CELL_BITS-1:0]  cell_value
);

  tmcw_cmd_t         cmd;
  tmcw_sts_t         sts;
  logic [ATTR_W-1:0] text_colour;
  logic              reg_sel;

  // The register file has one word. Address bits below the word index are
  // ignored, and the word at index one is unmapped: writes there are dropped
  // and reads return zero.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_TEXT_COLOUR);

  always_ff @(posedge clk) begin
    if (rst) begin
      text_colour <= RESET_COLOUR;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      text_colour <= pwdata[ATTR_W-1:0];
    end
  end

  always_comb begin
    if (reg_sel) begin
      prdata = {{(APB_DATA_W - ATTR_W){1'b0}}, text_colour};
    end else begin
      prdata = '0;
    end
  end

  // The controller sequences each item: execute, optional blanking sweep,
  // then load the output register. A new item is taken at the edge that
  // loads a result, provided the previous result has already left the
  // output register or leaves it at that same edge.
  tmcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath keeps the cells in a ring of rows so that a scroll moves
  // only the top-row offset and then blanks one row.
  tmcw_datapath #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .text_colour    (text_colour),
    .action         (action),
    .char_code      (char_code),
    .read_row       (read_row),
    .read_col       (read_col),
    .cursor_row_out (cursor_row_out),
    .cursor_col_out (cursor_col_out),
    .cursor_linear  (cursor_linear),
    .cell_value     (cell_value)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the text-mode console writer: puts, clears, cell reads
// and unused actions under random sender gaps and receiver stalls, checked per field.
// Depends on tmcw_pkg and the text_mode_console_writer RTL.
module testbench
  import tmcw_pkg::*;
();

  localparam int ROWS       = ROWS_DEF;
  localparam int COLUMNS    = COLUMNS_DEF;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  // The action code that the block must ignore apart from reporting the cursor.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // The colour register is word 0 of the configuration space.
  localparam logic [APB_ADDR_W-1:0] COLOUR_ADDR = {REG_TEXT_COLOUR, 2'b00};

  typedef struct packed {
    logic [ACT_W-1:0]     action;
    logic [CHAR_W-1:0]    ch;
    logic [ROW_OUT_W-1:0] rr;
    logic [COL_OUT_W-1:0] rc;
  } console_item_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic [LIN_OUT_W-1:0] linear;
    logic [CELL_BITS-1:0] cell_data;
  } console_result_t;

  // Patterns the receiver cycles through when deciding whether to stall.
  typedef enum {RX_FREE, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [ACT_W-1:0]      action    = '0;
  logic [CHAR_W-1:0]     char_code = '0;
  logic [ROW_OUT_W-1:0]  read_row  = '0;
  logic [COL_OUT_W-1:0]  read_col  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ROW_OUT_W-1:0]  cursor_row_out;
  logic [COL_OUT_W-1:0]  cursor_col_out;
  logic [LIN_OUT_W-1:0]  cursor_linear;
  logic [CELL_BITS-1:0]  cell_value;

  text_mode_console_writer #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .char_code      (char_code),
    .read_row       (read_row),
    .read_col       (read_col),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cursor_row_out (cursor_row_out),
    .cursor_col_out (cursor_col_out),
    .cursor_linear  (cursor_linear),
    .cell_value     (cell_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the screen, the cursor and the colour register.
  logic [CELL_BITS-1:0] screen_shadow [CELL_COUNT];
  int unsigned          shadow_row;
  int unsigned          shadow_col;
  logic [ATTR_W-1:0]    colour_shadow;

  // Results still owed by the block, oldest first.
  console_result_t pending_results[$];

  int mismatch_count = 0;
  int items_sent     = 0;
  int result_count   = 0;
  int put_count      = 0;
  int clear_count    = 0;
  int read_count     = 0;
  int unused_count   = 0;
  int scroll_count   = 0;
  int colour_writes  = 0;
  int burst_left     = 0;

  rx_mode_t    rx_mode      = RX_FREE;
  int unsigned rx_mode_left = 0;
  int unsigned rx_phase     = 0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Applies one item to the shadow state and returns the result the block must give.
  // The cursor row never exceeds the last row between items, so every cell index
  // formed from the cursor is inside the store.
  task automatic predict_console_action(input console_item_t item,
                                        output console_result_t res);
    logic [CELL_BITS-1:0] blank;
    int unsigned          linear;
    blank         = {colour_shadow, CH_SPACE};
    res.cell_data = '0;
    case (item.action)
      ACT_PUT: begin
        put_count++;
        case (item.ch)
          CH_NEWLINE: begin
            shadow_col = 0;
            shadow_row++;
          end
          CH_RETURN: begin
            shadow_col = 0;
          end
          CH_TAB: begin
            // Next multiple of four; the right edge wraps to the next row.
            shadow_col = (shadow_col + 4) & ~32'd3;
            if (shadow_col >= COLUMNS) begin
              shadow_col = 0;
              shadow_row++;
            end
          end
          CH_BACKSPACE: begin
            // Step back, across a row boundary if needed; at home it stays put.
            if (shadow_col > 0) begin
              shadow_col--;
            end else if (shadow_row > 0) begin
              shadow_row--;
              shadow_col = COLUMNS - 1;
            end
            screen_shadow[shadow_row * COLUMNS + shadow_col] = blank;
          end
          default: begin
            screen_shadow[shadow_row * COLUMNS + shadow_col] = {colour_shadow, item.ch};
            shadow_col++;
            if (shadow_col >= COLUMNS) begin
              shadow_col = 0;
              shadow_row++;
            end
          end
        endcase
        // Running off the bottom scrolls up one line and blanks the new last line.
        if (shadow_row >= ROWS) begin
          for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
            screen_shadow[i] = screen_shadow[i + COLUMNS];
          end
          for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
            screen_shadow[i] = blank;
          end
          shadow_row = ROWS - 1;
          scroll_count++;
        end
      end
      ACT_CLEAR: begin
        clear_count++;
        shadow_row = 0;
        shadow_col = 0;
        for (int i = 0; i < CELL_COUNT; i++) begin
          screen_shadow[i] = blank;
        end
      end
      ACT_READ: begin
        read_count++;
        if (item.rr < ROWS && item.rc < COLUMNS) begin
          res.cell_data = screen_shadow[item.rr * COLUMNS + item.rc];
        end
      end
      default: begin
        unused_count++;
      end
    endcase
    linear     = shadow_row * COLUMNS + shadow_col;
    res.row    = shadow_row[ROW_OUT_W-1:0];
    res.col    = shadow_col[COL_OUT_W-1:0];
    res.linear = linear[LIN_OUT_W-1:0];
  endtask

  function automatic console_item_t make_item(input logic [ACT_W-1:0] act,
                                              input logic [CHAR_W-1:0] ch,
                                              input logic [ROW_OUT_W-1:0] rr,
                                              input logic [COL_OUT_W-1:0] rc);
    console_item_t item;
    item.action = act;
    item.ch     = ch;
    item.rr     = rr;
    item.rc     = rc;
    return item;
  endfunction

  // Draws one random item. Text is the bulk; the percentages steer how often lines
  // end and how often the cursor walks backward, so phases reach different corners.
  function automatic console_item_t draw_console_item(input int newline_pct,
                                                      input int backspace_pct);
    console_item_t item;
    int            pick;
    int            ctl;
    item.action = ACT_PUT;
    item.ch     = CHAR_W'($urandom_range(0, 255));
    item.rr     = ROW_OUT_W'($urandom_range(0, 31));
    item.rc     = COL_OUT_W'($urandom_range(0, 127));
    pick        = $urandom_range(0, 99);
    if (pick < 2) begin
      item.action = ACT_CLEAR;
    end else if (pick < 4) begin
      item.action = ACT_UNUSED;
    end else if (pick < 20) begin
      item.action = ACT_READ;
      // Most reads land inside the screen, many on the cursor's own row.
      if ($urandom_range(0, 99) < 85) begin
        item.rr = ($urandom_range(0, 1) == 0) ? shadow_row[ROW_OUT_W-1:0]
                                              : ROW_OUT_W'($urandom_range(0, ROWS - 1));
        item.rc = COL_OUT_W'($urandom_range(0, COLUMNS - 1));
      end
    end else begin
      ctl = $urandom_range(0, 99);
      if (ctl < newline_pct) begin
        item.ch = CH_NEWLINE;
      end else if (ctl < newline_pct + backspace_pct) begin
        item.ch = CH_BACKSPACE;
      end else if (ctl < newline_pct + backspace_pct + 4) begin
        item.ch = CH_TAB;
      end else if (ctl < newline_pct + backspace_pct + 7) begin
        item.ch = CH_RETURN;
      end
    end
    return item;
  endfunction

  // Sends one item in the sender's burst pattern and records what it must produce.
  task automatic send_item(input console_item_t item);
    console_result_t res;
    int              gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    action    <= item.action;
    char_code <= item.ch;
    read_row  <= item.rr;
    read_col  <= item.rc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_console_action(item, res);
    pending_results.push_back(res);
    items_sent++;
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Writes the colour register, then reads it back in the following transfer.
  task automatic write_text_colour(input logic [ATTR_W-1:0] colour);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= COLOUR_ADDR;
    pwdata  <= {{(APB_DATA_W - ATTR_W){1'b0}}, colour};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    colour_shadow = colour;
    colour_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[ATTR_W-1:0] !== colour) begin
      report_mismatch($sformatf("text_colour read back %0h, expected %0h",
                                prdata[ATTR_W-1:0], colour));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Extremes of each field, every action and the named corner cases, in colour 7.
  task automatic test_directed_cases();
    // Freshly reset store: first and last cells are blanks in the reset colour.
    send_item(make_item(ACT_READ, 8'h00, 5'd0, 7'd0));
    send_item(make_item(ACT_READ, 8'hFF, 5'd24, 7'd79));
    // Plain text including the top-bit bytes and a zero byte.
    send_item(make_item(ACT_PUT, 8'h41, 5'd31, 7'd127));
    send_item(make_item(ACT_PUT, 8'hFF, 5'd0, 7'd0));
    send_item(make_item(ACT_PUT, 8'h80, 5'd0, 7'd0));
    send_item(make_item(ACT_PUT, 8'h00, 5'd0, 7'd0));
    // Tab from column four goes to eight; backspace then blanks column seven.
    send_item(make_item(ACT_PUT, CH_TAB, 5'd0, 7'd0));
    send_item(make_item(ACT_PUT, CH_BACKSPACE, 5'd0, 7'd0));
    send_item(make_item(ACT_PUT, CH_RETURN, 5'd0, 7'd0));
    send_item(make_item(ACT_READ, 8'h00, 5'd0, 7'd1));
    send_item(make_item(ACT_READ, 8'h00, 5'd0, 7'd3));
    send_item(make_item(ACT_READ, 8'h00, 5'd0, 7'd7));
    // Newline then backspace crosses back to the end of row zero.
    send_item(make_item(ACT_PUT, CH_NEWLINE, 5'd0, 7'd0));
    send_item(make_item(ACT_PUT, CH_BACKSPACE, 5'd0, 7'd0));
    // Reads outside the screen in either direction give zero.
    send_item(make_item(ACT_READ, 8'h00, 5'd31, 7'd127));
    send_item(make_item(ACT_READ, 8'h00, 5'd25, 7'd0));
    send_item(make_item(ACT_READ, 8'h00, 5'd0, 7'd80));
    // The unused action only reports the cursor.
    send_item(make_item(ACT_UNUSED, 8'hFF, 5'd31, 7'd127));
    // Clear, then backspace at home stays at home and blanks cell zero.
    send_item(make_item(ACT_CLEAR, 8'h55, 5'd10, 7'd42));
    send_item(make_item(ACT_PUT, CH_BACKSPACE, 5'd0, 7'd0));
    send_item(make_item(ACT_READ, 8'h00, 5'd0, 7'd0));
    send_item(make_item(ACT_READ, 8'h00, 5'd0, 7'd79));
  endtask

  // One colour setting followed by a stretch of random items.
  task automatic test_random_phase(input logic [ATTR_W-1:0] colour, input int count,
                                   input int newline_pct, input int backspace_pct);
    wait_for_drain();
    write_text_colour(colour);
    for (int n = 0; n < count; n++) begin
      send_item(draw_console_item(newline_pct, backspace_pct));
      // Now and then the sender waits for the block to empty out completely.
      if ($urandom_range(0, 199) == 0) begin
        wait_for_drain();
      end
    end
  endtask

  // Receiver stall pattern, independent of the sender.
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 300);
    end else begin
      rx_mode_left--;
    end
    rx_phase++;
    case (rx_mode)
      RX_FREE:     out_stall <= 1'b0;
      RX_LIGHT:    out_stall <= ($urandom_range(0, 99) < 25);
      RX_PERIODIC: out_stall <= (rx_phase % 4 == 3);
      default:     out_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  // Compares every accepted result with the oldest owed one.
  always @(posedge clk) begin : check_results
    console_result_t want;
    if (!rst && out_valid && !out_stall) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no item outstanding",
                                  result_count));
      end else begin
        want = pending_results.pop_front();
        if (cursor_row_out !== want.row) begin
          report_mismatch($sformatf("result %0d cursor_row_out %0d, expected %0d",
                                    result_count, cursor_row_out, want.row));
        end
        if (cursor_col_out !== want.col) begin
          report_mismatch($sformatf("result %0d cursor_col_out %0d, expected %0d",
                                    result_count, cursor_col_out, want.col));
        end
        if (cursor_linear !== want.linear) begin
          report_mismatch($sformatf("result %0d cursor_linear %0d, expected %0d",
                                    result_count, cursor_linear, want.linear));
        end
        if (cell_value !== want.cell_data) begin
          report_mismatch($sformatf("result %0d cell_value %04h, expected %04h",
                                    result_count, cell_value, want.cell_data));
        end
      end
    end
  end

  initial begin
    colour_shadow = RESET_COLOUR;
    shadow_row    = 0;
    shadow_col    = 0;
    for (int i = 0; i < CELL_COUNT; i++) begin
      screen_shadow[i] = {RESET_COLOUR, CH_SPACE};
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    // Black on black, ordinary text with short lines.
    test_random_phase(8'h00, 330, 6, 4);
    // All ones, long lines so that wraps and tab wraps at the right edge happen.
    test_random_phase(8'hFF, 330, 1, 2);
    // Any colour, many newlines so the screen scrolls often.
    test_random_phase(ATTR_W'($urandom_range(0, 255)), 330, 30, 3);
    // Yellow on blue, heavy backspacing that walks back over row boundaries.
    test_random_phase(8'h1E, 330, 4, 35);
    // Back to the reset colour with an even mix.
    test_random_phase(RESET_COLOUR, 300, 10, 10);

    wait_for_drain();
    repeat (64) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("Covered %0d items: %0d puts, %0d clears, %0d cell reads, %0d unused actions.",
             items_sent, put_count, clear_count, read_count, unused_count);
    $display("The screen scrolled %0d times; text colour was set %0d times; %0d mismatches.",
             scroll_count, colour_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS text_mode_console_writer");
    end else begin
      $display("FAIL text_mode_console_writer");
    end
    $finish;
  end

  // Watchdog: far beyond the longest run the stimulus above can take.
  initial begin
    #100ms;
    $display("Timed out waiting on the block.");
    $display("FAIL text_mode_console_writer");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tmcw_pkg.sv
rtl/core/tmcw_ctrl.sv
rtl/core/tmcw_datapath.sv
rtl/core/text_mode_console_writer.sv
bench/testbench.sv
